### rtl/stld_pkg.sv
// Shared constants, types and register indexes of the sequential turn-signal LED driver.
`default_nettype none
package stld_pkg;

    localparam int ROWS      = 8;
    localparam int COLS      = 8;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W     = 4;
    localparam int MAP_DEPTH = ROWS * COLS;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int PIX_W     = 8;
    localparam int COLOR_W   = 8;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = CFG_IDX_W'(6);

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_MAP_WR  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]   cols_eff;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] row_start;
        logic [CNT_W-1:0] row_count;
        logic             on;
        logic             active;
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_map_wr;

endpackage
`default_nettype wire

### rtl/stld_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/stld_front.sv
// Front end: configuration registers, input acceptance, timing state and row commands.
`default_nettype none
module stld_front
    import stld_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [S_TDATA_W-1:0]  i_tdata,
    input  wire logic                  i_tuser,
    output t_cfg                       o_cfg,
    output t_map_wr                    o_map_wr,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    input  wire logic                  i_q_full,
    input  wire logic                  i_q_empty,
    input  wire logic                  i_back_busy
);

    logic [CNT_W-1:0]   r_rows;
    logic [CNT_W-1:0]   r_cols;
    logic [COLOR_W-1:0] r_red;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_blue;
    logic [MS_W-1:0]    r_step;
    logic [MS_W-1:0]    r_holdoff;

    logic [TIME_W-1:0]  r_now, n_now;
    logic [TIME_W-1:0]  r_next, n_next;
    logic [TIME_W-1:0]  r_deadline, n_deadline;
    logic [ROW_W-1:0]   r_ptr, n_ptr;
    logic               r_phase, n_phase;
    logic               r_lit, n_lit;

    logic               sig_on;
    logic [2:0]         map_row;
    logic [2:0]         map_col;
    logic [PIX_W-1:0]   map_pixel;
    logic               accept;
    logic               tick_acc;
    logic               pseudo;
    logic               step_due;
    logic [CNT_W-1:0]   rows_eff;
    logic [CNT_W-1:0]   cols_eff;
    logic [CNT_W-1:0]   ptr_inc;
    t_cmd               cmd;

    assign sig_on    = i_tdata[0];
    assign map_row   = i_tdata[3:1];
    assign map_col   = i_tdata[6:4];
    assign map_pixel = i_tdata[14:7];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_tuser == REQ_MAP_WR) begin
            o_tready = i_q_empty && !i_back_busy;
        end else begin
            o_tready = !i_q_full;
        end
    end

    assign accept   = i_tvalid && o_tready;
    assign tick_acc = accept && (i_tuser == REQ_TICK);

    always_comb begin
        if (r_rows == '0) begin
            rows_eff = CNT_W'(1);
        end else if (r_rows > CNT_W'(ROWS)) begin
            rows_eff = CNT_W'(ROWS);
        end else begin
            rows_eff = r_rows;
        end
        if (r_cols > CNT_W'(COLS)) begin
            cols_eff = CNT_W'(COLS);
        end else begin
            cols_eff = r_cols;
        end
    end

    always_comb begin
        o_map_wr.we   = accept && (i_tuser == REQ_MAP_WR)
                        && (int'(map_row) < ROWS) && (int'(map_col) < COLS);
        o_map_wr.addr = ADDR_W'(int'(map_row) * COLS + int'(map_col));
        o_map_wr.data = map_pixel;
    end

    assign pseudo   = sig_on || (r_deadline > r_now);
    assign step_due = r_next < r_now;
    assign ptr_inc  = CNT_W'(r_ptr) + CNT_W'(1);

    always_comb begin
        n_now      = r_now;
        n_next     = r_next;
        n_deadline = r_deadline;
        n_ptr      = r_ptr;
        n_phase    = r_phase;
        n_lit      = r_lit;
        cmd        = '0;
        if (tick_acc) begin
            n_now = r_now + TIME_W'(1);
            if (sig_on) begin
                n_deadline = r_now + TIME_W'(r_holdoff);
            end
            if (pseudo) begin
                n_lit = 1'b1;
                if (step_due) begin
                    cmd.emit      = (cols_eff != '0);
                    cmd.row_start = r_ptr;
                    cmd.row_count = CNT_W'(1);
                    cmd.on        = !r_phase;
                    n_next        = r_now + TIME_W'(r_step);
                    if (ptr_inc >= rows_eff) begin
                        n_ptr   = '0;
                        n_phase = !r_phase;
                    end else begin
                        n_ptr = ROW_W'(ptr_inc);
                    end
                end
            end else if (r_lit && step_due) begin
                cmd.emit      = (cols_eff != '0);
                cmd.row_start = '0;
                cmd.row_count = rows_eff;
                cmd.on        = 1'b0;
                n_lit         = 1'b0;
                n_ptr         = '0;
                n_phase       = 1'b0;
            end
            cmd.active = n_lit;
        end
    end

    assign o_push = tick_acc;
    assign o_cmd  = cmd;

    assign o_cfg.cols_eff = cols_eff;
    assign o_cfg.red      = r_red;
    assign o_cfg.green    = r_green;
    assign o_cfg.blue     = r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= CNT_W'(8);
            r_cols     <= CNT_W'(8);
            r_red      <= COLOR_W'(255);
            r_green    <= COLOR_W'(128);
            r_blue     <= '0;
            r_step     <= MS_W'(100);
            r_holdoff  <= MS_W'(500);
            r_now      <= TIME_W'(1);
            r_next     <= '0;
            r_deadline <= '0;
            r_ptr      <= '0;
            r_phase    <= 1'b0;
            r_lit      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROWS_IN_USE: r_rows    <= i_cfg_data[CNT_W-1:0];
                    REG_COLS_IN_USE: r_cols    <= i_cfg_data[CNT_W-1:0];
                    REG_COLOR_RED:   r_red     <= i_cfg_data[COLOR_W-1:0];
                    REG_COLOR_GREEN: r_green   <= i_cfg_data[COLOR_W-1:0];
                    REG_COLOR_BLUE:  r_blue    <= i_cfg_data[COLOR_W-1:0];
                    REG_STEP_PERIOD: r_step    <= i_cfg_data[MS_W-1:0];
                    REG_HOLDOFF:     r_holdoff <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            r_now      <= n_now;
            r_next     <= n_next;
            r_deadline <= n_deadline;
            r_ptr      <= n_ptr;
            r_phase    <= n_phase;
            r_lit      <= n_lit;
        end
    end

endmodule
`default_nettype wire

### rtl/stld_cmd_fifo.sv
// Short command queue between the front end and the pixel write back end.
`default_nettype none
module stld_cmd_fifo
    import stld_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty,
    output logic      o_full
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command popped from an empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> !o_empty)
        else $error("pushed command lost");

endmodule
`default_nettype wire

### rtl/stld_back.sv
// Back end: walks the pixel map for each command that emits writes and drives the result register.
`default_nettype none
module stld_back
    import stld_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_q_empty,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [ADDR_W-1:0]          o_rd_addr,
    input  wire logic [PIX_W-1:0]      i_rd_data,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [M_TDATA_W-1:0]       o_tdata,
    output logic                       o_tuser,
    output logic                       o_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_row;
    logic [CNT_W-1:0]     r_row_last;
    logic [CNT_W-1:0]     r_col;
    logic                 r_on;
    logic                 r_active;
    logic                 r_pend;
    logic                 r_pend_last;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_tdata;
    logic                 r_tuser;
    logic                 r_tlast;

    logic                 take;
    logic                 out_free;
    logic                 issue;
    logic                 col_end;
    logic                 cur_last;

    assign take     = r_out_valid && i_tready;
    assign out_free = !r_out_valid || take;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty && !r_pend && out_free;
    assign issue    = (r_state == ST_RUN) && !r_pend && out_free;
    assign col_end  = (r_col == i_cfg.cols_eff - CNT_W'(1));
    assign cur_last = col_end && (r_row == r_row_last);

    assign o_rd_en   = issue;
    assign o_rd_addr = ADDR_W'(int'(r_row) * COLS + int'(r_col));
    assign o_busy    = (r_state != ST_IDLE) || r_pend || r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (o_pop && i_cmd.emit) begin
                n_state = ST_RUN;
            end
            ST_RUN: if (issue && cur_last) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row      <= CNT_W'(i_cmd.row_start);
            r_row_last <= CNT_W'(i_cmd.row_start) + i_cmd.row_count - CNT_W'(1);
            r_col      <= '0;
            r_on       <= i_cmd.on;
            r_active   <= i_cmd.active;
        end else if (issue) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= r_row + CNT_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
        if (issue) begin
            r_pend_last <= cur_last;
        end
        if (r_pend) begin
            r_tdata <= M_TDATA_W'({r_active,
                                   r_on ? i_cfg.blue  : COLOR_W'(0),
                                   r_on ? i_cfg.green : COLOR_W'(0),
                                   r_on ? i_cfg.red   : COLOR_W'(0),
                                   i_rd_data});
            r_tuser <= 1'b1;
            r_tlast <= r_pend_last;
        end else if (o_pop && !i_cmd.emit) begin
            r_tdata <= M_TDATA_W'({i_cmd.active, {3{COLOR_W'(0)}}, PIX_W'(0)});
            r_tuser <= 1'b0;
            r_tlast <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (r_pend || (o_pop && !i_cmd.emit)) begin
                r_out_valid <= 1'b1;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_pend)
        else $error("map read issued without data landing");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("map data landed on an occupied result register");

    a_pop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_pend && !issue)
        else $error("command popped while a row is still being written");

endmodule
`default_nettype wire

### rtl/sequential_turn_signal_led_driver.sv
// Top level of the sequential turn-signal LED driver.
//
// s_axis carries input items: tuser is the request kind (tick or map write),
// tdata holds signal_on, map_row, map_col and map_pixel. Ticks are one
// millisecond apart. Each tick returns either one status result or one
// pixel write per column of each row it changes; tlast marks the final
// write of a tick, the point at which the strip is shown. Map writes load
// the row-by-column pixel map and return nothing.
// The cfg channel writes registers by index and is always ready.
// A tick's status result passes through the command queue and then the
// result register. A pixel write run passes through the queue and then,
// for each write, a map read and the output register; a new map read is
// issued only once the last one has landed. A two-entry command queue
// lets ticks be taken while earlier writes drain. A map write waits until
// the queue and the write engine are empty. When m_axis stalls, the result
// register holds and the queue fills, then s_axis deasserts tready.
// Reset restores the register defaults and clears the timing state; the
// map is not cleared and must be loaded before use.
`default_nettype none
module sequential_turn_signal_led_driver
    import stld_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // signal_on, map_row, map_col, map_pixel
    input  wire logic                  s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,  // pixel_index, red, green, blue, active
    output logic                       m_axis_tuser,  // write_valid
    output logic                       m_axis_tlast
);

    t_cfg             cfg;
    t_map_wr          map_wr;
    logic             push;
    t_cmd             cmd;
    t_cmd             head;
    logic             q_empty;
    logic             q_full;
    logic             pop;
    logic             back_busy;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0] rd_data;

    stld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_cfg       (cfg),
        .o_map_wr    (map_wr),
        .o_push      (push),
        .o_cmd       (cmd),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_busy (back_busy)
    );

    stld_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    stld_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_wr.we),
        .i_waddr (map_wr.addr),
        .i_wdata (map_wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    stld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (head),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_busy    (back_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule
`default_nettype wire
